// ===== rtl/core/rcsc_pkg.sv =====
package rcsc_pkg;

    // Result kind codes carried on m_tuser
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_SCREEN = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    // Register reset values
    localparam logic signed [13:0] CENTER_X_RESET = 14'sd550;
    localparam logic signed [13:0] CENTER_Y_RESET = 14'sd300;
    localparam logic [11:0]        RADIUS_RESET   = 12'd140;

    // Datapath widths
    localparam int DISC_W  = 62;          // discriminant, always below 2^61
    localparam int ROOT_W  = DISC_W / 2;  // integer square root
    localparam int NUM_W   = 31;          // divider numerator magnitude
    localparam int FRAC_W  = 22;          // Q2.14 direction -> Q12.8 result
    localparam int QUO_W   = NUM_W + FRAC_W;
    localparam int SCR_Q_W = 36;          // screen quotient magnitude bits in use
    localparam int LIM_W   = 13;          // screen limit, up to 8191

    localparam logic [19:0] DIST_MAX = 20'hFFFFF;

    // One ray as it enters
    typedef struct packed {
        logic [11:0]        sx;
        logic [11:0]        sy;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } ray_t;

    // Data that rides along the square root pipeline
    typedef struct packed {
        ray_t               ray;
        logic               zero;
        logic [31:0]        a;
        logic signed [31:0] b;
        logic               disc_neg;
    } sq_side_t;

    // Data that rides along the circle divider
    typedef struct packed {
        logic zero;
        logic obs_ok;
        logic dx_nz;
        logic dy_nz;
        logic dx_neg;
        logic dy_neg;
    } cdiv_side_t;

endpackage

// ===== rtl/core/rcsc_quad.sv =====
module rcsc_quad (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rcsc_pkg::ray_t                in_ray,
    input  logic signed [13:0]            cx,
    input  logic signed [13:0]            cy,
    input  logic [11:0]                   r,
    output logic                          out_valid,
    output rcsc_pkg::sq_side_t            out_side,
    output logic [rcsc_pkg::DISC_W-1:0]   out_disc
);

    // Stage A: offsets from the center, r squared
    logic                a_valid_reg;
    rcsc_pkg::ray_t      a_ray_reg;
    logic signed [14:0]  a_ox_reg, a_oy_reg;
    logic [23:0]         a_rr_reg;
    logic                a_zero_reg;

    // Stage B: products
    logic                b_valid_reg;
    rcsc_pkg::ray_t      b_ray_reg;
    logic                b_zero_reg;
    logic signed [31:0]  b_dx2_reg, b_dy2_reg;
    logic signed [30:0]  b_oxdx_reg, b_oydy_reg;
    logic signed [29:0]  b_ox2_reg, b_oy2_reg;
    logic [23:0]         b_rr_reg;

    // Stage C: quadratic coefficients
    logic                c_valid_reg;
    rcsc_pkg::ray_t      c_ray_reg;
    logic                c_zero_reg;
    logic [31:0]         c_a_reg;
    logic signed [31:0]  c_b_reg;
    logic signed [30:0]  c_c_reg;

    // Stage D: b*b and a*c
    logic                d_valid_reg;
    rcsc_pkg::ray_t      d_ray_reg;
    logic                d_zero_reg;
    logic [31:0]         d_a_reg;
    logic signed [31:0]  d_b_reg;
    logic [61:0]         d_bb_reg;
    logic signed [63:0]  d_ac_reg;

    // Stage E: discriminant
    logic                e_valid_reg;
    rcsc_pkg::sq_side_t  e_side_reg;
    logic [rcsc_pkg::DISC_W-1:0] e_disc_reg;

    logic signed [14:0]  ox_next, oy_next;
    logic signed [31:0]  dx2_next, dy2_next;
    logic signed [30:0]  oxdx_next, oydy_next;
    logic signed [29:0]  ox2_next, oy2_next;
    logic signed [31:0]  b_next;
    logic signed [30:0]  c_next;
    logic signed [63:0]  bb_full, ac_next, disc_next;

    always_comb
    begin
        ox_next   = $signed({3'b000, in_ray.sx}) - $signed({cx[13], cx});
        oy_next   = $signed({3'b000, in_ray.sy}) - $signed({cy[13], cy});
        dx2_next  = a_ray_reg.dx * a_ray_reg.dx;
        dy2_next  = a_ray_reg.dy * a_ray_reg.dy;
        oxdx_next = a_ox_reg * a_ray_reg.dx;
        oydy_next = a_oy_reg * a_ray_reg.dy;
        ox2_next  = a_ox_reg * a_ox_reg;
        oy2_next  = a_oy_reg * a_oy_reg;
        b_next    = b_oxdx_reg + b_oydy_reg;
        c_next    = b_ox2_reg + b_oy2_reg - $signed({7'b0, b_rr_reg});
        bb_full   = c_b_reg * c_b_reg;
        ac_next   = $signed({1'b0, c_a_reg}) * c_c_reg;
        disc_next = $signed({2'b00, d_bb_reg}) - d_ac_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ray_reg  <= in_ray;
            a_ox_reg   <= ox_next;
            a_oy_reg   <= oy_next;
            a_rr_reg   <= r * r;
            a_zero_reg <= (in_ray.dx == 16'sd0) && (in_ray.dy == 16'sd0);

            b_ray_reg  <= a_ray_reg;
            b_zero_reg <= a_zero_reg;
            b_dx2_reg  <= dx2_next;
            b_dy2_reg  <= dy2_next;
            b_oxdx_reg <= oxdx_next;
            b_oydy_reg <= oydy_next;
            b_ox2_reg  <= ox2_next;
            b_oy2_reg  <= oy2_next;
            b_rr_reg   <= a_rr_reg;

            c_ray_reg  <= b_ray_reg;
            c_zero_reg <= b_zero_reg;
            c_a_reg    <= b_dx2_reg + b_dy2_reg;
            c_b_reg    <= b_next;
            c_c_reg    <= c_next;

            d_ray_reg  <= c_ray_reg;
            d_zero_reg <= c_zero_reg;
            d_a_reg    <= c_a_reg;
            d_b_reg    <= c_b_reg;
            d_bb_reg   <= bb_full[61:0];
            d_ac_reg   <= ac_next;

            e_side_reg.ray      <= d_ray_reg;
            e_side_reg.zero     <= d_zero_reg;
            e_side_reg.a        <= d_a_reg;
            e_side_reg.b        <= d_b_reg;
            e_side_reg.disc_neg <= disc_next[63];
            e_disc_reg          <= disc_next[63] ? '0 : disc_next[rcsc_pkg::DISC_W-1:0];
        end
    end

    assign out_valid = e_valid_reg;
    assign out_side  = e_side_reg;
    assign out_disc  = e_disc_reg;

endmodule

// ===== rtl/core/rcsc_sqrt.sv =====
module rcsc_sqrt #(
    parameter int IN_W   = 62,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_x,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int STAGES = IN_W / 2;
    localparam logic [IN_W-1:0] ONE = {{(IN_W-1){1'b0}}, 1'b1};

    logic [IN_W-1:0]   x_reg   [STAGES];
    logic [IN_W-1:0]   res_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic              valid_reg [STAGES];

    // One result bit per stage, digit-by-digit restoring root
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic [IN_W-1:0] BIT = ONE << (IN_W - 2 - 2 * i);

        logic [IN_W-1:0]   x_src, res_src, x_nx, res_nx;
        logic [SIDE_W-1:0] side_src;
        logic              valid_src;
        logic [IN_W:0]     trial;

        if (i == 0)
        begin : g_first
            assign x_src     = in_x;
            assign res_src   = '0;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign x_src     = x_reg[i-1];
            assign res_src   = res_reg[i-1];
            assign side_src  = side_reg[i-1];
            assign valid_src = valid_reg[i-1];
        end

        always_comb
        begin
            trial = {1'b0, res_src} + {1'b0, BIT};
            if ({1'b0, x_src} >= trial)
            begin
                x_nx   = x_src - trial[IN_W-1:0];
                res_nx = (res_src >> 1) + BIT;
            end
            else
            begin
                x_nx   = x_src;
                res_nx = res_src >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_nx;
                res_reg[i]  <= res_nx;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = res_reg[STAGES-1][STAGES-1:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== rtl/core/rcsc_div.sv =====
module rcsc_div #(
    parameter int NUM_W  = 31,
    parameter int DEN_W  = 32,
    parameter int FRAC_W = 22,
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [NUM_W-1:0]           in_num,
    input  logic [DEN_W-1:0]           in_den,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [NUM_W+FRAC_W-1:0]    out_quo,
    output logic                       out_rem_nz,
    output logic [SIDE_W-1:0]          out_side
);

    // floor(num * 2^FRAC_W / den), one quotient bit per stage
    localparam int Q_W = NUM_W + FRAC_W;

    logic [NUM_W-1:0]  num_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              valid_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [NUM_W-1:0]  num_src;
        logic [DEN_W-1:0]  den_src, rem_src, rem_nx;
        logic [Q_W-1:0]    quo_src;
        logic [SIDE_W-1:0] side_src;
        logic              valid_src, qbit;
        logic [DEN_W:0]    trial;

        if (i == 0)
        begin : g_first
            assign num_src   = in_num;
            assign den_src   = in_den;
            assign rem_src   = '0;
            assign quo_src   = '0;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign num_src   = num_reg[i-1];
            assign den_src   = den_reg[i-1];
            assign rem_src   = rem_reg[i-1];
            assign quo_src   = quo_reg[i-1];
            assign side_src  = side_reg[i-1];
            assign valid_src = valid_reg[i-1];
        end

        // Shift in the next dividend bit (zeros once the numerator is used up)
        always_comb
        begin
            trial = {rem_src, num_src[NUM_W-1]};
            qbit  = (trial >= {1'b0, den_src});
            if (qbit)
                rem_nx = trial[DEN_W-1:0] - den_src;
            else
                rem_nx = trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i]  <= {num_src[NUM_W-2:0], 1'b0};
                den_reg[i]  <= den_src;
                rem_reg[i]  <= rem_nx;
                quo_reg[i]  <= {quo_src[Q_W-2:0], qbit};
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid  = valid_reg[Q_W-1];
    assign out_quo    = quo_reg[Q_W-1];
    assign out_rem_nz = (rem_reg[Q_W-1] != '0);
    assign out_side   = side_reg[Q_W-1];

endmodule

// ===== rtl/core/ray_circle_screen_clip.sv =====
// Pipeline: 5 coefficient stages, 31 square-root stages, 1 root-select stage,
// 53 divider stages and 2 output stages lie between an accepted ray and its result item.
// Throughput: one ray per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so a stall at m_tready holds every stage.
// Reset: asynchronous, active low; clears all valid bits and loads the circle
// registers with center (550, 300) and radius 140.
module ray_circle_screen_clip #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
) (
    input  logic        clk,
    input  logic        rst_n,
    // Ray input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // start_x[11:0], start_y[23:12], dir_x[39:24], dir_y[55:40]
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hit_distance[19:0], step_count[30:20], zero[31]
    output logic [1:0]  m_tuser,   // hit_kind[1:0]
    // Configuration writes
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int NW = rcsc_pkg::NUM_W;
    localparam int QW = rcsc_pkg::QUO_W;
    localparam int SQ = rcsc_pkg::SCR_Q_W;
    localparam int LW = rcsc_pkg::LIM_W;
    localparam logic [LW-1:0] W_LIM = LW'(SCREEN_WIDTH);
    localparam logic [LW-1:0] H_LIM = LW'(SCREEN_HEIGHT);

    logic en;

    // Circle configuration
    logic signed [13:0] cx_reg, cy_reg;
    logic [11:0]        r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= rcsc_pkg::CENTER_X_RESET;
            cy_reg <= rcsc_pkg::CENTER_Y_RESET;
            r_reg  <= rcsc_pkg::RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rcsc_pkg::REG_CENTER_X: cx_reg <= cfg_data;
                rcsc_pkg::REG_CENTER_Y: cy_reg <= cfg_data;
                rcsc_pkg::REG_RADIUS:   r_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Quadratic coefficients and discriminant
    rcsc_pkg::ray_t     in_ray;
    logic               q_valid;
    rcsc_pkg::sq_side_t q_side;
    logic [rcsc_pkg::DISC_W-1:0] q_disc;

    assign in_ray.sx = s_tdata[11:0];
    assign in_ray.sy = s_tdata[23:12];
    assign in_ray.dx = s_tdata[39:24];
    assign in_ray.dy = s_tdata[55:40];

    rcsc_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_ray    (in_ray),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .r         (r_reg),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_disc  (q_disc)
    );

    // Square root of the discriminant
    logic                         sq_valid;
    logic [rcsc_pkg::ROOT_W-1:0]  sq_root;
    logic [$bits(rcsc_pkg::sq_side_t)-1:0] sq_side_vec;
    rcsc_pkg::sq_side_t           sq_side;

    rcsc_sqrt #(
        .IN_W   (rcsc_pkg::DISC_W),
        .SIDE_W ($bits(rcsc_pkg::sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_x      (q_disc),
        .in_side   (q_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_vec)
    );

    assign sq_side = sq_side_vec;

    // Stage F: pick the circle root, set up slab numerators
    logic signed [33:0] b_ext, s_ext, n1, n2;
    logic               n1_ok, n2_ok;
    logic signed [13:0] xhi, yhi;
    logic [LW-1:0]      xhi_mag, yhi_mag;

    always_comb
    begin
        b_ext = {{2{sq_side.b[31]}}, sq_side.b};
        s_ext = $signed({3'b000, sq_root});
        n1    = -b_ext - s_ext;
        n2    = -b_ext + s_ext;
        // quotient is at least one LSB only when n * 2^22 >= a
        n1_ok = !sq_side.disc_neg && !n1[33] && (n1 != 34'sd0)
                && ({n1[NW-1:0], {rcsc_pkg::FRAC_W{1'b0}}} >= QW'(sq_side.a));
        n2_ok = !sq_side.disc_neg && !n2[33] && (n2 != 34'sd0)
                && ({n2[NW-1:0], {rcsc_pkg::FRAC_W{1'b0}}} >= QW'(sq_side.a));
        xhi   = $signed({1'b0, W_LIM}) - $signed({2'b00, sq_side.ray.sx});
        yhi   = $signed({1'b0, H_LIM}) - $signed({2'b00, sq_side.ray.sy});
        xhi_mag = xhi[13] ? LW'(-xhi) : xhi[LW-1:0];
        yhi_mag = yhi[13] ? LW'(-yhi) : yhi[LW-1:0];
    end

    logic                 f_valid_reg;
    logic [NW-1:0]        f_num_reg;
    logic [31:0]          f_a_reg;
    rcsc_pkg::cdiv_side_t f_side_reg;
    logic [NW-1:0]        f_xlo_reg, f_xhi_reg, f_ylo_reg, f_yhi_reg;
    logic [15:0]          f_dxm_reg, f_dym_reg;
    logic                 f_xlo_flip_reg, f_xhi_flip_reg, f_ylo_flip_reg, f_yhi_flip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_num_reg         <= n1_ok ? n1[NW-1:0] : n2[NW-1:0];
            f_a_reg           <= sq_side.a;
            f_side_reg.zero   <= sq_side.zero;
            f_side_reg.obs_ok <= n1_ok || n2_ok;
            f_side_reg.dx_nz  <= (sq_side.ray.dx != 16'sd0);
            f_side_reg.dy_nz  <= (sq_side.ray.dy != 16'sd0);
            f_side_reg.dx_neg <= sq_side.ray.dx[15];
            f_side_reg.dy_neg <= sq_side.ray.dy[15];
            f_xlo_reg         <= NW'(sq_side.ray.sx);
            f_ylo_reg         <= NW'(sq_side.ray.sy);
            f_xhi_reg         <= NW'(xhi_mag);
            f_yhi_reg         <= NW'(yhi_mag);
            f_dxm_reg         <= sq_side.ray.dx[15] ? 16'(-sq_side.ray.dx) : sq_side.ray.dx;
            f_dym_reg         <= sq_side.ray.dy[15] ? 16'(-sq_side.ray.dy) : sq_side.ray.dy;
            // floor of a negative quotient needs the magnitude negated and rounded away
            f_xlo_flip_reg    <= (sq_side.ray.sx != 12'd0) && !sq_side.ray.dx[15];
            f_ylo_flip_reg    <= (sq_side.ray.sy != 12'd0) && !sq_side.ray.dy[15];
            f_xhi_flip_reg    <= (xhi != 14'sd0) && (xhi[13] != sq_side.ray.dx[15]);
            f_yhi_flip_reg    <= (yhi != 14'sd0) && (yhi[13] != sq_side.ray.dy[15]);
        end
    end

    // Dividers: circle hit and the four slab planes
    logic                 cd_valid, dxl_valid, dxh_valid, dyl_valid, dyh_valid;
    logic [QW-1:0]        cd_quo, dxl_quo, dxh_quo, dyl_quo, dyh_quo;
    logic                 cd_rnz, dxl_rnz, dxh_rnz, dyl_rnz, dyh_rnz;
    logic [$bits(rcsc_pkg::cdiv_side_t)-1:0] cd_side_vec;
    rcsc_pkg::cdiv_side_t cd_side;
    logic                 dxl_flip, dxh_flip, dyl_flip, dyh_flip;

    rcsc_div #(
        .NUM_W (NW), .DEN_W (32), .FRAC_W (rcsc_pkg::FRAC_W),
        .SIDE_W ($bits(rcsc_pkg::cdiv_side_t))
    ) u_div_circle (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (f_valid_reg), .in_num (f_num_reg), .in_den (f_a_reg),
        .in_side (f_side_reg),
        .out_valid (cd_valid), .out_quo (cd_quo), .out_rem_nz (cd_rnz),
        .out_side (cd_side_vec)
    );

    rcsc_div #(
        .NUM_W (NW), .DEN_W (16), .FRAC_W (rcsc_pkg::FRAC_W), .SIDE_W (1)
    ) u_div_xlo (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (f_valid_reg), .in_num (f_xlo_reg), .in_den (f_dxm_reg),
        .in_side (f_xlo_flip_reg),
        .out_valid (dxl_valid), .out_quo (dxl_quo), .out_rem_nz (dxl_rnz),
        .out_side (dxl_flip)
    );

    rcsc_div #(
        .NUM_W (NW), .DEN_W (16), .FRAC_W (rcsc_pkg::FRAC_W), .SIDE_W (1)
    ) u_div_xhi (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (f_valid_reg), .in_num (f_xhi_reg), .in_den (f_dxm_reg),
        .in_side (f_xhi_flip_reg),
        .out_valid (dxh_valid), .out_quo (dxh_quo), .out_rem_nz (dxh_rnz),
        .out_side (dxh_flip)
    );

    rcsc_div #(
        .NUM_W (NW), .DEN_W (16), .FRAC_W (rcsc_pkg::FRAC_W), .SIDE_W (1)
    ) u_div_ylo (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (f_valid_reg), .in_num (f_ylo_reg), .in_den (f_dym_reg),
        .in_side (f_ylo_flip_reg),
        .out_valid (dyl_valid), .out_quo (dyl_quo), .out_rem_nz (dyl_rnz),
        .out_side (dyl_flip)
    );

    rcsc_div #(
        .NUM_W (NW), .DEN_W (16), .FRAC_W (rcsc_pkg::FRAC_W), .SIDE_W (1)
    ) u_div_yhi (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (f_valid_reg), .in_num (f_yhi_reg), .in_den (f_dym_reg),
        .in_side (f_yhi_flip_reg),
        .out_valid (dyh_valid), .out_quo (dyh_quo), .out_rem_nz (dyh_rnz),
        .out_side (dyh_flip)
    );

    assign cd_side = cd_side_vec;

    // Signed floor from magnitude quotient
    function automatic logic signed [SQ:0] floor_q(logic [SQ-1:0] q, logic rnz, logic flip);
        logic signed [SQ:0] m;
        m = $signed({1'b0, q});
        if (flip)
            return -(m + $signed({{SQ{1'b0}}, rnz}));
        return m;
    endfunction

    // Stage G: slab entry and exit
    logic signed [SQ:0] xlo_t, xhi_t, ylo_t, yhi_t, xmin, xmax, ymin, ymax;
    logic signed [SQ:0] tmin_next, tmax_next;

    always_comb
    begin
        xlo_t = floor_q(dxl_quo[SQ-1:0], dxl_rnz, dxl_flip);
        xhi_t = floor_q(dxh_quo[SQ-1:0], dxh_rnz, dxh_flip);
        ylo_t = floor_q(dyl_quo[SQ-1:0], dyl_rnz, dyl_flip);
        yhi_t = floor_q(dyh_quo[SQ-1:0], dyh_rnz, dyh_flip);
        xmin  = cd_side.dx_neg ? xhi_t : xlo_t;
        xmax  = cd_side.dx_neg ? xlo_t : xhi_t;
        ymin  = cd_side.dy_neg ? yhi_t : ylo_t;
        ymax  = cd_side.dy_neg ? ylo_t : yhi_t;

        tmin_next = '0;
        if (cd_side.dx_nz && xmin > tmin_next)
            tmin_next = xmin;
        if (cd_side.dy_nz && ymin > tmin_next)
            tmin_next = ymin;

        if (cd_side.dx_nz && cd_side.dy_nz)
            tmax_next = (xmax < ymax) ? xmax : ymax;
        else if (cd_side.dx_nz)
            tmax_next = xmax;
        else
            tmax_next = ymax;
    end

    logic               g_valid_reg;
    logic signed [SQ:0] g_tmin_reg, g_tmax_reg;
    logic [QW-1:0]      g_obs_reg;
    logic               g_obs_ok_reg, g_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= cd_valid && dxl_valid && dxh_valid && dyl_valid && dyh_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_tmin_reg   <= tmin_next;
            g_tmax_reg   <= tmax_next;
            g_obs_reg    <= cd_quo;
            g_obs_ok_reg <= cd_side.obs_ok;
            g_zero_reg   <= cd_side.zero;
        end
    end

    // Stage H: choose the nearer hit, saturate
    logic            scr_ok, pick_obs;
    rcsc_pkg::kind_t kind_next;
    logic [19:0]     dist_next;

    always_comb
    begin
        scr_ok   = (g_tmax_reg >= g_tmin_reg) && (g_tmax_reg > 0);
        pick_obs = g_obs_ok_reg && (!scr_ok || (g_obs_reg < QW'(g_tmax_reg[SQ-1:0])));
        if (g_zero_reg)
        begin
            kind_next = rcsc_pkg::KIND_NONE;
            dist_next = '0;
        end
        else if (pick_obs)
        begin
            kind_next = rcsc_pkg::KIND_CIRCLE;
            dist_next = (g_obs_reg[QW-1:20] != '0) ? rcsc_pkg::DIST_MAX : g_obs_reg[19:0];
        end
        else if (scr_ok)
        begin
            kind_next = rcsc_pkg::KIND_SCREEN;
            dist_next = (g_tmax_reg[SQ-1:20] != '0) ? rcsc_pkg::DIST_MAX : g_tmax_reg[19:0];
        end
        else
        begin
            kind_next = rcsc_pkg::KIND_NONE;
            dist_next = '0;
        end
    end

    logic            out_valid_reg;
    logic [19:0]     out_dist_reg;
    rcsc_pkg::kind_t out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= dist_next;
            out_kind_reg <= kind_next;
        end
    end

    // Global advance: output register empty or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_dist_reg[19:9], out_dist_reg};
    assign m_tuser  = out_kind_reg;

    // A miss carries zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rcsc_pkg::KIND_NONE)) |-> (m_tdata == 32'd0))
        else $error("miss with nonzero distance");

    // Any reported hit lies strictly ahead of the origin
    a_hit_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != rcsc_pkg::KIND_NONE)) |-> (m_tdata[19:0] != 20'd0))
        else $error("hit with zero distance");

    // Input is held back only by a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A stalled result does not advance the pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(g_tmax_reg) && $stable(g_valid_reg)))
        else $error("pipeline moved during output stall");

endmodule

// ===== tb/tb_ray_circle_screen_clip.sv =====
module tb_ray_circle_screen_clip;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W       = 1920;
    localparam int SCR_H       = 1080;
    localparam int LATENCY     = 92;
    localparam int HOLD_CYCLES = 300;

    // Index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [19:0]       distance;
        rcsc_pkg::kind_t   kind;
        logic [10:0]       steps;
    } hit_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;

    ray_circle_screen_clip u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Circle registers as the predictor sees them
    longint cx = 550;
    longint cy = 300;
    longint rad = 140;

    logic [55:0] ray_q[$];
    hit_t        hit_q[$];
    int          errors = 0;
    int          rays_sent = 0;
    int          hits_checked = 0;
    int          kind_seen[3] = '{0, 0, 0};
    bit          hold_rx = 0;
    bit          burst_mode = 1;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Integer square root, floor
    function automatic longint isqrt(longint x);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 32'h7FFF_FFFF;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    // Nearest hit of one ray against the circle and the screen
    function automatic hit_t trace_ray(logic [55:0] ray);
        hit_t   h;
        longint sx, sy, dx, dy;
        longint ox, oy, a, b, c, disc, s, n1, n2, t1, t2;
        longint obs, best, tmin, tmax, u1, u2, tmp;
        bit     obs_ok, scr_ok;
        sx = ray[11:0];
        sy = ray[23:12];
        dx = longint'($signed(ray[39:24]));
        dy = longint'($signed(ray[55:40]));
        h.distance = '0;
        h.kind = rcsc_pkg::KIND_NONE;
        h.steps = '0;
        if (dx == 0 && dy == 0)
            return h;
        obs = 0;
        obs_ok = 0;
        ox = sx - cx;
        oy = sy - cy;
        a = dx * dx + dy * dy;
        b = ox * dx + oy * dy;
        c = ox * ox + oy * oy - rad * rad;
        disc = b * b - a * c;
        if (disc >= 0)
        begin
            s = isqrt(disc);
            n1 = -b - s;
            n2 = -b + s;
            t1 = (n1 > 0) ? (n1 * 4194304) / a : 0;
            t2 = (n2 > 0) ? (n2 * 4194304) / a : 0;
            if (t1 > 0)
            begin
                obs = t1;
                obs_ok = 1;
            end
            else if (t2 > 0)
            begin
                obs = t2;
                obs_ok = 1;
            end
        end
        // Slab clip, skipping a zero axis
        tmin = 0;
        tmax = 64'sh7FFF_FFFF_FFFF_FFFF;
        if (dx != 0)
        begin
            u1 = fdiv(-sx * 4194304, dx);
            u2 = fdiv((SCR_W - sx) * 4194304, dx);
            if (u1 > u2)
            begin
                tmp = u1;
                u1 = u2;
                u2 = tmp;
            end
            if (u1 > tmin) tmin = u1;
            if (u2 < tmax) tmax = u2;
        end
        if (dy != 0)
        begin
            u1 = fdiv(-sy * 4194304, dy);
            u2 = fdiv((SCR_H - sy) * 4194304, dy);
            if (u1 > u2)
            begin
                tmp = u1;
                u1 = u2;
                u2 = tmp;
            end
            if (u1 > tmin) tmin = u1;
            if (u2 < tmax) tmax = u2;
        end
        scr_ok = (tmax >= tmin) && (tmax > 0);
        if (obs_ok && (!scr_ok || obs < tmax))
        begin
            best = obs;
            h.kind = rcsc_pkg::KIND_CIRCLE;
        end
        else if (scr_ok)
        begin
            best = tmax;
            h.kind = rcsc_pkg::KIND_SCREEN;
        end
        else
            return h;
        if (best > 1048575)
            best = 1048575;
        h.distance = best[19:0];
        h.steps = best[19:9];
        return h;
    endfunction

    function automatic logic [55:0] pack_ray(int sx, int sy, int dx, int dy);
        logic [15:0] ux;
        logic [15:0] uy;
        ux = 16'(dx);
        uy = 16'(dy);
        return {uy, ux, sy[11:0], sx[11:0]};
    endfunction

    // Random direction: mostly near unit length, sometimes axis-aligned, tiny or anywhere in +/-16384
    function automatic logic [55:0] rand_ray();
        int     sx, sy, dx, dy;
        real    ang;
        sx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1950);
        sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1100);
        case ($urandom_range(0, 9))
            0: begin dx = $urandom_range(0, 32768) - 16384; dy = $urandom_range(0, 32768) - 16384; end
            1: begin dx = 0; dy = $urandom_range(0, 1) ? 16384 : -16384; end
            2: begin dy = 0; dx = $urandom_range(0, 1) ? 16384 : -16384; end
            3: begin dx = $urandom_range(0, 6) - 3; dy = $urandom_range(0, 6) - 3; end
            default:
            begin
                ang = $urandom_range(0, 62831) / 10000.0;
                dx = $rtoi(16384.0 * $cos(ang));
                dy = $rtoi(16384.0 * $sin(ang));
            end
        endcase
        return pack_ray(sx, sy, dx, dy);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [13:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            rcsc_pkg::REG_CENTER_X: cx = longint'($signed(val));
            rcsc_pkg::REG_CENTER_Y: cy = longint'($signed(val));
            rcsc_pkg::REG_RADIUS:   rad = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain_and_settle();
        while (ray_q.size() != 0 || hit_q.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // Input handshake as seen at the rising edge
    bit in_acc = 0;
    always @(posedge clk)
        in_acc <= rst_n && s_tvalid && s_tready;

    // Driver: bursts with random gaps while burst_mode is set
    int gap = 0;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                hit_q.push_back(trace_ray(s_tdata));
                rays_sent++;
            end
            if (s_tvalid && !in_acc)
                ;
            else if (gap > 0)
            begin
                gap--;
                s_tvalid <= 1'b0;
            end
            else if (ray_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= ray_q.pop_front();
                if (burst_mode && $urandom_range(0, 7) == 0)
                    gap = $urandom_range(1, 12);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stall pattern, plus a long hold when asked
    int rx_phase = 0;
    int hold_cnt = 0;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_rx && hold_cnt < HOLD_CYCLES)
        begin
            hold_cnt++;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_phase = (rx_phase + 1) % 400;
            if (rx_phase < 150)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        hit_t exp_hit;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hit_q.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
            end
            else
            begin
                exp_hit = hit_q.pop_front();
                hits_checked++;
                if (m_tuser < 3)
                    kind_seen[m_tuser]++;
                if (m_tdata[19:0] !== exp_hit.distance)
                begin
                    $error("hit_distance expected %0d got %0d", exp_hit.distance, m_tdata[19:0]);
                    errors++;
                end
                if (m_tuser !== exp_hit.kind)
                begin
                    $error("hit_kind expected %0d got %0d", exp_hit.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[30:20] !== exp_hit.steps)
                begin
                    $error("step_count expected %0d got %0d", exp_hit.steps, m_tdata[30:20]);
                    errors++;
                end
            end
        end
    end

    task automatic push_directed();
        ray_q.push_back(pack_ray(0, 0, 0, 0));
        ray_q.push_back(pack_ray(4095, 4095, 0, 0));
        ray_q.push_back(pack_ray(0, 0, 16384, 0));
        ray_q.push_back(pack_ray(0, 0, 0, 16384));
        ray_q.push_back(pack_ray(0, 0, -16384, 0));
        ray_q.push_back(pack_ray(0, 0, -16384, -16384));
        ray_q.push_back(pack_ray(4095, 4095, -16384, -16384));
        ray_q.push_back(pack_ray(4095, 4095, 16384, 16384));
        ray_q.push_back(pack_ray(100, 300, 16384, 0));
        ray_q.push_back(pack_ray(550, 300, 16384, 0));
        ray_q.push_back(pack_ray(550, 300, 0, -16384));
        ray_q.push_back(pack_ray(900, 300, -16384, 0));
        ray_q.push_back(pack_ray(100, 160, 16384, 0));
        ray_q.push_back(pack_ray(960, 540, 1, 0));
        ray_q.push_back(pack_ray(960, 540, 0, -1));
        ray_q.push_back(pack_ray(960, 540, -1, 1));
        ray_q.push_back(pack_ray(0, 540, 32767, 32767));
        ray_q.push_back(pack_ray(1920, 1080, 16384, 0));
        ray_q.push_back(pack_ray(3000, 540, -16384, 0));
        ray_q.push_back(pack_ray(2730, 2730, 16'h5555, 16'hAAAA));
        ray_q.push_back(pack_ray(1365, 1365, 16'hAAAA, 16'h5555));
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset circle, directed then random
        push_directed();
        repeat (200) ray_q.push_back(rand_ray());
        drain_and_settle();

        // Long receiver hold while the sender keeps offering
        hold_rx = 1;
        repeat (150) ray_q.push_back(rand_ray());
        wait (hold_cnt == HOLD_CYCLES);
        hold_rx = 0;
        drain_and_settle();

        // Extreme register settings
        write_reg(rcsc_pkg::REG_CENTER_X, 14'h1FFF);
        write_reg(rcsc_pkg::REG_CENTER_Y, 14'h2000);
        write_reg(rcsc_pkg::REG_RADIUS, 14'd4095);
        push_directed();
        repeat (150) ray_q.push_back(rand_ray());
        drain_and_settle();

        write_reg(rcsc_pkg::REG_CENTER_X, 14'h2000);
        write_reg(rcsc_pkg::REG_CENTER_Y, 14'h1FFF);
        write_reg(rcsc_pkg::REG_RADIUS, 14'd0);
        repeat (100) ray_q.push_back(rand_ray());
        drain_and_settle();

        write_reg(REG_UNUSED, 14'h3FFF);
        write_reg(rcsc_pkg::REG_CENTER_X, 14'd960);
        write_reg(rcsc_pkg::REG_CENTER_Y, 14'd540);
        write_reg(rcsc_pkg::REG_RADIUS, 14'd300);
        push_directed();
        burst_mode = 0;
        repeat (150) ray_q.push_back(rand_ray());
        drain_and_settle();
        burst_mode = 1;

        for (int k = 0; k < 3; k++)
        begin
            write_reg(rcsc_pkg::REG_CENTER_X, 14'($urandom_range(0, 16383)));
            write_reg(rcsc_pkg::REG_CENTER_Y, 14'($urandom_range(0, 16383)));
            write_reg(rcsc_pkg::REG_RADIUS, 14'($urandom_range(0, 600)));
            repeat (70) ray_q.push_back(rand_ray());
            drain_and_settle();
        end

        $display("%0d rays checked in %0d results: none %0d, circle %0d, screen %0d",
                 rays_sent, hits_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("register settings covered reset, extremes, an ignored index and random circles");
        if (errors == 0 && hit_q.size() == 0)
            $display("ray_circle_screen_clip regression: pass");
        else
            $display("ray_circle_screen_clip regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("ray_circle_screen_clip regression: fail");
        $finish;
    end
endmodule

// ===== ray_circle_screen_clip.f =====
rtl/core/rcsc_pkg.sv
rtl/core/rcsc_quad.sv
rtl/core/rcsc_sqrt.sv
rtl/core/rcsc_div.sv
rtl/core/ray_circle_screen_clip.sv
tb/tb_ray_circle_screen_clip.sv
